FILE: rtl/core/mrq_pkg.sv
// ----------------------------------------------------------------------------
// mrq_pkg: shared constants and types of the message ring queue
// Sizes of the store, field widths, command and status codes, and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mrq_pkg;

  // store geometry
  localparam int SLOTS     = 16;
  localparam int MAX_BYTES = 64;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int ADDR_W    = $clog2(SLOTS * MAX_BYTES);

  // fixed field widths
  localparam int CMD_W     = 2;
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 7;
  localparam int STAT_W    = 2;
  localparam int SLOTCFG_W = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 7;

  // register reset values
  localparam logic [SLOTCFG_W-1:0] SLOTS_RESET   = SLOTCFG_W'(16);
  localparam logic [LEN_W-1:0]     MAXLEN_RESET  = LEN_W'(64);
  localparam logic [LEN_W-1:0]     LEN_SATURATE  = LEN_W'(127);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES    = 1'd1;

  // request commands
  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_TOO_LONG = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic fire;       // request accepted this cycle
    logic load_byte;  // move the fetched pop byte into the output register
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic res_now;    // accepted request yields one result at once
    logic pop_start;  // accepted request starts a byte stream
    logic pop_last;   // byte being loaded is the last of the stream
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/message_ring_queue_top.sv
// ----------------------------------------------------------------------------
// message_ring_queue_top: ring queue of variable-length byte messages
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i/in_ready_o   cmd, data_byte, has_byte,
//                                                end_of_message, pop_limit
//   out       output     out_valid_o/out_ready_i out_byte, is_data, out_last,
//                                                status, out_length,
//                                                stored_count
//   cfg       input      cfg_we_i                cfg_index_i, cfg_data_i
//
// Push, clear and empty or zero-length pop requests each give one result.
// A pop of n bytes is read one byte per cycle while the output register is
// free, through the single read port of the message store; no request is
// taken until the last byte is in the output register.
// A request is taken only while the output register is empty or being read.
// Reset clears cursors, count and push state at once; the message store and
// slot lengths hold no reset and get no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module message_ring_queue_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [mrq_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [mrq_pkg::CFG_W-1:0]     cfg_data_i,
  // request channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [mrq_pkg::CMD_W-1:0]     cmd_i,
  input  wire logic [mrq_pkg::BYTE_W-1:0]    data_byte_i,
  input  wire logic                          has_byte_i,
  input  wire logic                          end_of_message_i,
  input  wire logic [mrq_pkg::LEN_W-1:0]     pop_limit_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [mrq_pkg::BYTE_W-1:0]         out_byte_o,
  output logic                               is_data_o,
  output logic                               out_last_o,
  output logic [mrq_pkg::STAT_W-1:0]         status_o,
  output logic [mrq_pkg::LEN_W-1:0]          out_length_o,
  output logic [mrq_pkg::CNT_W-1:0]          stored_count_o
);

  import mrq_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;

  mrq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (dp_stat),
    .cmd_o       (ctl_cmd)
  );

  mrq_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd_i),
    .data_byte_i      (data_byte_i),
    .has_byte_i       (has_byte_i),
    .end_of_message_i (end_of_message_i),
    .pop_limit_i      (pop_limit_i),
    .cmd_ctl_i        (ctl_cmd),
    .stat_o           (dp_stat),
    .out_byte_o       (out_byte_o),
    .is_data_o        (is_data_o),
    .out_last_o       (out_last_o),
    .status_o         (status_o),
    .out_length_o     (out_length_o),
    .stored_count_o   (stored_count_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/mrq_ram.sv
// ----------------------------------------------------------------------------
// mrq_ram: generic simple dual-port RAM
// One write port, one read port with registered read data held until the
// next read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module mrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/mrq_ctrl.sv
// ----------------------------------------------------------------------------
// mrq_ctrl: request sequencer of the message ring queue
// Gates request acceptance, owns the output valid flag and steps through
// the bytes of a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module mrq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire mrq_pkg::dp_stat_t stat_i,
  output mrq_pkg::ctl_cmd_t      cmd_o
);

  import mrq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;
  logic   fire;
  logic   load_byte;

  // output register is free when empty or being taken now
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign fire       = in_valid_i && in_ready_o;
  assign load_byte  = (state_q == S_POP) && out_free;

  assign cmd_o.fire      = fire;
  assign cmd_o.load_byte = load_byte;
  assign out_valid_o     = out_valid_q;

  // hold state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (fire && stat_i.pop_start) begin
            state_q <= S_POP;
          end
        end
        S_POP: begin
          if (load_byte && stat_i.pop_last) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      if ((fire && stat_i.res_now) || load_byte) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mrq_dp.sv
// ----------------------------------------------------------------------------
// mrq_dp: datapath of the message ring queue
// Ring cursors, message count, push tracking, slot lengths, the message
// store and the output result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrq_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration
  input  wire logic                            cfg_we_i,
  input  wire logic [mrq_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [mrq_pkg::CFG_W-1:0]       cfg_data_i,
  // request fields
  input  wire logic [mrq_pkg::CMD_W-1:0]       cmd_i,
  input  wire logic [mrq_pkg::BYTE_W-1:0]      data_byte_i,
  input  wire logic                            has_byte_i,
  input  wire logic                            end_of_message_i,
  input  wire logic [mrq_pkg::LEN_W-1:0]       pop_limit_i,
  // controller link
  input  wire mrq_pkg::ctl_cmd_t               cmd_ctl_i,
  output mrq_pkg::dp_stat_t                    stat_o,
  // result fields
  output logic [mrq_pkg::BYTE_W-1:0]           out_byte_o,
  output logic                                 is_data_o,
  output logic                                 out_last_o,
  output logic [mrq_pkg::STAT_W-1:0]           status_o,
  output logic [mrq_pkg::LEN_W-1:0]            out_length_o,
  output logic [mrq_pkg::CNT_W-1:0]            stored_count_o
);

  import mrq_pkg::*;

  // configuration registers
  logic [SLOTCFG_W-1:0] slots_cfg_q;
  logic [LEN_W-1:0]     maxlen_cfg_q;

  // control state
  logic [SLOT_W-1:0] wr_slot_q, wr_slot_d;
  logic [SLOT_W-1:0] rd_slot_q, rd_slot_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [LEN_W-1:0]  push_cnt_q, push_cnt_d;
  logic              push_rej_q, push_rej_d;
  logic              push_act_q, push_act_d;
  logic [LEN_W-1:0]  pop_k_q, pop_k_d;

  // payload state
  logic [LEN_W-1:0]  slot_len_q [SLOTS];
  logic [SLOT_W-1:0] pop_slot_q;
  logic [LEN_W-1:0]  pop_n_q;

  // output register
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              is_data_q, is_data_d;
  logic              out_last_q, out_last_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [LEN_W-1:0]  out_len_q, out_len_d;
  logic [CNT_W-1:0]  out_cnt_q;

  // working signals
  logic [CNT_W-1:0]  eff_slots;
  logic [LEN_W-1:0]  maxlen;
  logic [LEN_W-1:0]  limit;
  logic              rej_now;
  logic [LEN_W-1:0]  cnt_base;
  logic [LEN_W-1:0]  cnt_new;
  logic [LEN_W-1:0]  pop_n;
  logic              len_we;
  logic              res_now;
  logic              pop_start;
  logic              pop_last;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  // wrap a slot index over the slots in use
  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
                                                  input logic [CNT_W-1:0]  lim);
    logic [CNT_W-1:0] n;
    n = CNT_W'(s) + CNT_W'(1);
    return (n >= lim) ? '0 : n[SLOT_W-1:0];
  endfunction

  // start address of a slot in the message store
  function automatic logic [ADDR_W-1:0] slot_base(input logic [SLOT_W-1:0] s);
    return ADDR_W'(ADDR_W'(s) * ADDR_W'(MAX_BYTES));
  endfunction

  // saturate configuration and pop limit
  always_comb begin
    if (slots_cfg_q == '0) begin
      eff_slots = CNT_W'(1);
    end else if (CNT_W'(slots_cfg_q) > CNT_W'(SLOTS)) begin
      eff_slots = CNT_W'(SLOTS);
    end else begin
      eff_slots = CNT_W'(slots_cfg_q);
    end
    maxlen = (maxlen_cfg_q > LEN_W'(MAX_BYTES)) ? LEN_W'(MAX_BYTES) : maxlen_cfg_q;
    limit  = (pop_limit_i > LEN_W'(MAX_BYTES)) ? LEN_W'(MAX_BYTES) : pop_limit_i;
  end

  // push tracking: first item samples fullness and restarts the count
  assign rej_now  = push_act_q ? push_rej_q : (count_q >= eff_slots);
  assign cnt_base = push_act_q ? push_cnt_q : '0;
  assign cnt_new  = (has_byte_i && (cnt_base < LEN_SATURATE)) ? cnt_base + LEN_W'(1)
                                                               : cnt_base;
  assign ram_we    = cmd_ctl_i.fire && (cmd_i == CMD_PUSH) && has_byte_i && !rej_now
                     && (cnt_base < LEN_W'(MAX_BYTES));
  assign ram_waddr = slot_base(wr_slot_q) + ADDR_W'(cnt_base);

  // pop length and stream position
  assign pop_n    = (slot_len_q[rd_slot_q] > limit) ? limit : slot_len_q[rd_slot_q];
  assign pop_last = (pop_k_q + LEN_W'(1)) == pop_n_q;

  // decode the request and build the immediate result
  always_comb begin
    wr_slot_d  = wr_slot_q;
    rd_slot_d  = rd_slot_q;
    count_d    = count_q;
    push_cnt_d = push_cnt_q;
    push_rej_d = push_rej_q;
    push_act_d = push_act_q;
    len_we     = 1'b0;
    res_now    = 1'b0;
    pop_start  = 1'b0;
    out_byte_d = '0;
    is_data_d  = 1'b0;
    out_last_d = 1'b1;
    status_d   = ST_OK;
    out_len_d  = '0;
    unique case (cmd_i)
      CMD_PUSH: begin
        if (end_of_message_i) begin
          res_now    = 1'b1;
          push_act_d = 1'b0;
          push_cnt_d = '0;
          push_rej_d = rej_now;
          if (rej_now) begin
            status_d = ST_FULL;
          end else if (cnt_new > maxlen) begin
            status_d = ST_TOO_LONG;
          end else begin
            len_we    = 1'b1;
            out_len_d = cnt_new;
            wr_slot_d = next_slot(wr_slot_q, eff_slots);
            count_d   = count_q + CNT_W'(1);
          end
        end else begin
          push_act_d = 1'b1;
          push_cnt_d = cnt_new;
          push_rej_d = rej_now;
        end
      end
      CMD_POP: begin
        if (count_q == '0) begin
          res_now  = 1'b1;
          status_d = ST_EMPTY;
        end else begin
          rd_slot_d = next_slot(rd_slot_q, eff_slots);
          count_d   = count_q - CNT_W'(1);
          if (pop_n == '0) begin
            res_now = 1'b1;
          end else begin
            pop_start = 1'b1;
          end
        end
      end
      CMD_CLEAR: begin
        res_now    = 1'b1;
        wr_slot_d  = '0;
        rd_slot_d  = '0;
        count_d    = '0;
        push_act_d = 1'b0;
        push_cnt_d = '0;
        push_rej_d = 1'b0;
      end
      default: begin
        // unused code: no result, no change
      end
    endcase
  end

  // fetch the first byte at pop start, the next one as each byte is loaded
  assign ram_re    = (cmd_ctl_i.fire && pop_start) || (cmd_ctl_i.load_byte && !pop_last);
  assign ram_raddr = cmd_ctl_i.fire ? slot_base(rd_slot_q)
                                    : slot_base(pop_slot_q) + ADDR_W'(pop_k_q + LEN_W'(1));

  always_comb begin
    pop_k_d = pop_k_q;
    if (cmd_ctl_i.fire && pop_start) begin
      pop_k_d = '0;
    end else if (cmd_ctl_i.load_byte) begin
      pop_k_d = pop_k_q + LEN_W'(1);
    end
  end

  assign stat_o.res_now   = res_now;
  assign stat_o.pop_start = pop_start;
  assign stat_o.pop_last  = pop_last;

  // hold configuration and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_cfg_q  <= SLOTS_RESET;
      maxlen_cfg_q <= MAXLEN_RESET;
      wr_slot_q    <= '0;
      rd_slot_q    <= '0;
      count_q      <= '0;
      push_cnt_q   <= '0;
      push_rej_q   <= 1'b0;
      push_act_q   <= 1'b0;
      pop_k_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_SLOTS_IN_USE: slots_cfg_q  <= cfg_data_i[SLOTCFG_W-1:0];
          CFG_MAX_BYTES:    maxlen_cfg_q <= cfg_data_i[LEN_W-1:0];
          default: ;
        endcase
      end
      if (cmd_ctl_i.fire) begin
        wr_slot_q  <= wr_slot_d;
        rd_slot_q  <= rd_slot_d;
        count_q    <= count_d;
        push_cnt_q <= push_cnt_d;
        push_rej_q <= push_rej_d;
        push_act_q <= push_act_d;
      end
      pop_k_q <= pop_k_d;
    end
  end

  // payload: slot lengths, pop context, output register
  always_ff @(posedge clk_i) begin
    if (cmd_ctl_i.fire && len_we) begin
      slot_len_q[wr_slot_q] <= cnt_new;
    end
    if (cmd_ctl_i.fire && pop_start) begin
      pop_slot_q <= rd_slot_q;
      pop_n_q    <= pop_n;
    end
    if (cmd_ctl_i.fire && res_now) begin
      out_byte_q <= out_byte_d;
      is_data_q  <= is_data_d;
      out_last_q <= out_last_d;
      status_q   <= status_d;
      out_len_q  <= out_len_d;
      out_cnt_q  <= count_d;
    end else if (cmd_ctl_i.load_byte) begin
      out_byte_q <= ram_rdata;
      is_data_q  <= 1'b1;
      out_last_q <= pop_last;
      status_q   <= ST_OK;
      out_len_q  <= pop_n_q;
      out_cnt_q  <= count_q;
    end
  end

  mrq_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SLOTS * MAX_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (data_byte_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_byte_o     = out_byte_q;
  assign is_data_o      = is_data_q;
  assign out_last_o     = out_last_q;
  assign status_o       = status_q;
  assign out_length_o   = out_len_q;
  assign stored_count_o = out_cnt_q;

endmodule

`default_nettype wire
